// ===== design/fbsc_pkg.sv =====
// shared types and constants for the frustum box/sphere cull block
package fbsc_pkg;

    localparam int COORD_WIDTH     = 20;
    localparam int NORMAL_WIDTH    = 16;
    localparam int NUM_PLANES      = 4;
    localparam int NUM_AXES        = 3;
    localparam int FRAC_SHIFT      = 14;
    localparam int DIST_WIDTH      = COORD_WIDTH + 1;
    localparam int RADIUS_WIDTH    = COORD_WIDTH - 1;
    localparam int PROD_WIDTH      = COORD_WIDTH + NORMAL_WIDTH;
    localparam int DOT_WIDTH       = PROD_WIDTH + 2;
    localparam int THR_WIDTH       = DIST_WIDTH + 1;
    localparam int PACK_WIDTH      = NORMAL_WIDTH * NUM_AXES;
    localparam int CFG_COUNT       = 2 * NUM_PLANES;
    localparam int CFG_INDEX_WIDTH = $clog2(CFG_COUNT);
    localparam int CFG_DATA_WIDTH  = PACK_WIDTH;
    localparam int PIPE_DEPTH      = 2 * NUM_PLANES + 1;
    localparam int OCC_WIDTH       = $clog2(PIPE_DEPTH + 1);

    localparam logic CMD_BOX    = 1'b0;
    localparam logic CMD_SPHERE = 1'b1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE0_NORMAL = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE1_NORMAL = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE2_NORMAL = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE3_NORMAL = CFG_INDEX_WIDTH'(3);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE0_DIST   = CFG_INDEX_WIDTH'(4);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE1_DIST   = CFG_INDEX_WIDTH'(5);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE2_DIST   = CFG_INDEX_WIDTH'(6);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANE3_DIST   = CFG_INDEX_WIDTH'(7);

    typedef logic signed [COORD_WIDTH-1:0]  coord_t;
    typedef logic signed [NORMAL_WIDTH-1:0] normal_t;
    typedef logic signed [DIST_WIDTH-1:0]   dist_t;
    typedef logic signed [PROD_WIDTH-1:0]   prod_t;
    typedef logic signed [DOT_WIDTH-1:0]    dot_t;
    typedef logic signed [THR_WIDTH-1:0]    thr_t;

    typedef struct packed {
        normal_t [NUM_AXES-1:0] normal;
        dist_t                  distance;
    } plane_t;

    typedef struct packed {
        logic                    command;
        coord_t [NUM_AXES-1:0]   lo;
        coord_t [NUM_AXES-1:0]   hi;
        logic [RADIUS_WIDTH-1:0] radius;
        logic [NUM_PLANES-1:0]   mask;
        logic                    culled;
    } item_t;

endpackage

// ===== design/fbsc_if.sv =====
// stream interfaces for bounds in and cull verdicts out
interface fbsc_in_if import fbsc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    command;
    coord_t                  lo_x;
    coord_t                  lo_y;
    coord_t                  lo_z;
    coord_t                  hi_x;
    coord_t                  hi_y;
    coord_t                  hi_z;
    logic [RADIUS_WIDTH-1:0] sphere_radius;
    logic [NUM_PLANES-1:0]   plane_mask;

    modport source (
        output valid, command, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, sphere_radius, plane_mask,
        input  ready
    );
    modport sink (
        input  valid, command, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, sphere_radius, plane_mask,
        output ready
    );
endinterface

interface fbsc_out_if;
    logic valid;
    logic ready;
    logic culled;

    modport source (
        output valid, culled,
        input  ready
    );
    modport sink (
        input  valid, culled,
        output ready
    );
endinterface

// ===== design/frustum_box_sphere_cull.sv =====
// frustum box/sphere cull top level: plane registers, cell chain, output register
//
//   channel   direction  carries
//   bounds    in         command, lo_x..z, hi_x..z, sphere_radius, plane_mask
//   verdict   out        culled
//   cfg       in         cfg_write, cfg_index, cfg_data
//
// one item per cycle while the verdict side takes them; a chain of four plane cells, two stages each
// the verdict passes through stage a and stage b of each cell in turn, then the output register
// each stage holds its item while the next is full, bubbles close up
// reset clears all plane registers and every valid flag
module frustum_box_sphere_cull
    import fbsc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    fbsc_in_if.sink                    bounds,
    fbsc_out_if.source                 verdict,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic [PACK_WIDTH-1:0] normal_reg [NUM_PLANES];
    dist_t                 dist_reg   [NUM_PLANES];
    plane_t                plane      [NUM_PLANES];

    item_t chain_item  [NUM_PLANES+1];
    logic  chain_valid [NUM_PLANES+1];
    logic  chain_ready [NUM_PLANES+1];

    logic  res_valid_reg, res_valid_next;
    logic  res_culled_reg;
    logic  res_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                normal_reg[p] <= '0;
                dist_reg[p]   <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PLANE0_NORMAL: normal_reg[0] <= cfg_data;
                REG_PLANE1_NORMAL: normal_reg[1] <= cfg_data;
                REG_PLANE2_NORMAL: normal_reg[2] <= cfg_data;
                REG_PLANE3_NORMAL: normal_reg[3] <= cfg_data;
                REG_PLANE0_DIST:   dist_reg[0]   <= cfg_data[DIST_WIDTH-1:0];
                REG_PLANE1_DIST:   dist_reg[1]   <= cfg_data[DIST_WIDTH-1:0];
                REG_PLANE2_DIST:   dist_reg[2]   <= cfg_data[DIST_WIDTH-1:0];
                REG_PLANE3_DIST:   dist_reg[3]   <= cfg_data[DIST_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        chain_valid[0]       = bounds.valid;
        chain_item[0].command = bounds.command;
        chain_item[0].lo      = {bounds.lo_z, bounds.lo_y, bounds.lo_x};
        chain_item[0].hi      = {bounds.hi_z, bounds.hi_y, bounds.hi_x};
        chain_item[0].radius  = bounds.sphere_radius;
        chain_item[0].mask    = bounds.plane_mask;
        chain_item[0].culled  = 1'b0;
    end

    assign bounds.ready = chain_ready[0];

    for (genvar i = 0; i < NUM_PLANES; i++)
    begin : g_cell
        assign plane[i].normal   = normal_reg[i];
        assign plane[i].distance = dist_reg[i];

        fbsc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .plane     (plane[i]),
            .plane_sel (NUM_PLANES'(1) << i),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .in_ready  (chain_ready[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1]),
            .out_ready (chain_ready[i+1])
        );
    end

    assign res_en                  = !res_valid_reg || verdict.ready;
    assign chain_ready[NUM_PLANES] = res_en;
    assign res_valid_next          = res_en ? chain_valid[NUM_PLANES] : res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_en)
            res_culled_reg <= chain_item[NUM_PLANES].culled;
    end

    assign verdict.valid  = res_valid_reg;
    assign verdict.culled = res_culled_reg;

endmodule

// ===== design/fbsc_cell.sv =====
// one plane cell: corner select and multiply, then sum and compare
module fbsc_cell
    import fbsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  plane_t                plane,
    input  logic [NUM_PLANES-1:0] plane_sel,
    input  logic                  in_valid,
    input  item_t                 in_item,
    output logic                  in_ready,
    output logic                  out_valid,
    output item_t                 out_item,
    input  logic                  out_ready
);

    logic  a_valid_reg, a_valid_next;
    item_t a_item_reg;
    prod_t [NUM_AXES-1:0] a_prod_reg, a_prod_next;
    thr_t  a_thr_reg, a_thr_next;
    logic  a_test_reg, a_test_next;
    logic  a_en;

    logic  b_valid_reg, b_valid_next;
    item_t b_item_reg, b_item_next;
    logic  b_en;

    coord_t [NUM_AXES-1:0] corner;
    dot_t  dot;
    dot_t  thr_scaled;
    logic  hit;

    assign b_en     = !b_valid_reg || out_ready;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    // stage a: pick the corner per axis, form the three products and the threshold
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (in_item.command == CMD_SPHERE || plane.normal[a][NORMAL_WIDTH-1])
                corner[a] = in_item.lo[a];
            else
                corner[a] = in_item.hi[a];
            a_prod_next[a] = $signed(plane.normal[a]) * $signed(corner[a]);
        end
        if (in_item.command == CMD_SPHERE)
        begin
            a_thr_next  = $signed({plane.distance[DIST_WIDTH-1], plane.distance})
                        - $signed({3'b000, in_item.radius});
            a_test_next = |(in_item.mask & plane_sel);
        end
        else
        begin
            a_thr_next  = $signed({plane.distance[DIST_WIDTH-1], plane.distance});
            a_test_next = 1'b1;
        end
    end

    assign a_valid_next = a_en ? in_valid : a_valid_reg;

    // stage b: sum of products against the scaled threshold
    always_comb
    begin
        dot = DOT_WIDTH'(a_prod_reg[0]) + DOT_WIDTH'(a_prod_reg[1])
            + DOT_WIDTH'(a_prod_reg[2]);
        thr_scaled = DOT_WIDTH'($signed({a_thr_reg, {FRAC_SHIFT{1'b0}}}));
        if (a_item_reg.command == CMD_SPHERE)
            hit = dot <= thr_scaled;
        else
            hit = dot < thr_scaled;
        b_item_next        = a_item_reg;
        b_item_next.culled = a_item_reg.culled | (a_test_reg & hit);
    end

    assign b_valid_next = b_en ? a_valid_reg : b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_item_reg <= in_item;
            a_prod_reg <= a_prod_next;
            a_thr_reg  <= a_thr_next;
            a_test_reg <= a_test_next;
        end
        if (b_en)
            b_item_reg <= b_item_next;
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

// ===== design/fbsc_checker.sv =====
// port-level checks for the frustum box/sphere cull block, bound to the top level
module fbsc_checker
    import fbsc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic culled
);

    logic [OCC_WIDTH-1:0] occ_reg, occ_next;
    logic                 in_xfer;
    logic                 out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_xfer && !out_xfer)
            occ_next = occ_reg + OCC_WIDTH'(1);
        else if (!in_xfer && out_xfer)
            occ_next = occ_reg - OCC_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    // items in flight never exceed the pipeline stages
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_WIDTH'(PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

    // no verdict without an accepted item behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != '0)
        else $error("verdict with no item in flight");

    // an empty output register never holds back input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is empty");

    // stalled verdict holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(culled))
        else $error("stalled verdict changed");

endmodule

bind frustum_box_sphere_cull fbsc_checker u_fbsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (bounds.valid),
    .in_ready  (bounds.ready),
    .out_valid (verdict.valid),
    .out_ready (verdict.ready),
    .culled    (verdict.culled)
);
